// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when the trigger holds, the consequence holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// File: sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// types and constants shared by the sha-256 engine
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned DEF_QUEUE_DEPTH = 4;
	localparam int unsigned LEN_HI_INDEX = 14;
	localparam logic [31:0] PAD_MARK = 32'h8000_0000;

	typedef logic [31:0] word_t;

	// one block word handed from the packer to the compression core
	typedef struct packed {
		word_t word;
		logic  final_blk;
	} qword_t;

	localparam word_t INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// File: sv/sha_ifs.sv
// ----------------------------------------------------------------------------
// sha channel interfaces
// message word channel and digest word channel
// ----------------------------------------------------------------------------
interface sha_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        end_of_message;

	modport source (output valid, data_word, byte_count, end_of_message, input ready);
	modport sink (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface sha_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/sha256_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// streaming sha-256 with byte packing, padding and digest output
// ----------------------------------------------------------------------------
// msg carries one big-endian word with 0 to 4 leading bytes and an end flag;
// digest returns the eight hash words, index 0 first, last_word on the eighth.
// both channels move one item per transfer when valid and ready are high.
// the packer takes a word per cycle while the queue has room and it is not
// padding; the core loads 16 words, runs 64 rounds at one per cycle and then
// adds the chain, so the compression loop sets the throughput.
// at message end the packer adds the pad marker, zero words and the two
// length words (up to one extra block), then the eight digest words follow
// one per cycle from an output register while the receiver is ready.
// a stalled digest receiver holds the core; the packer fills the queue and
// then drops msg.ready. reset clears all counters and loads the initial hash.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_hash_engine_unit
	import sha_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	sha_msg_if.sink   msg,
	sha_dig_if.source digest
);

	logic   push;
	qword_t push_word;
	logic   queue_full;
	logic   pop;
	qword_t pop_word;
	logic   queue_empty;

	sha_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push       (push),
		.push_word  (push_word),
		.queue_full (queue_full)
	);

	sha_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_word),
		.full   (queue_full),
		.pop    (pop),
		.rdata  (pop_word),
		.empty  (queue_empty)
	);

	sha_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_word    (pop_word),
		.queue_empty (queue_empty),
		.pop         (pop),
		.digest      (digest)
	);

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, !(push && queue_full), "push into full queue")
	`ASSERT_ALWAYS(a_no_underflow, clk, arst_n, !(pop && queue_empty), "pop from empty queue")
	`ASSERT_ALWAYS(a_last_index, clk, arst_n, !digest.valid || (digest.last_word == (digest.word_index == 3'd7)), "last_word out of step with index")
	`ASSERT_NEXT(a_wrap_index, clk, arst_n, digest.valid && digest.ready && digest.last_word, !digest.valid, "digest words beyond the eighth")

endmodule

// File: sv/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// packs message bytes into block words, adds padding and the bit length
// ----------------------------------------------------------------------------
module sha_front
	import sha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sha_msg_if.sink   msg,
	output logic      push,
	output qword_t    push_word,
	input  logic      queue_full
);

	typedef enum logic [2:0] {S_RUN, S_MARK, S_ZERO, S_LENHI, S_LENLO} state_t;

	state_t      state_q;
	logic [31:0] acc_q;
	logic [1:0]  nbytes_q;
	logic [3:0]  windex_q;
	logic [63:0] bitlen_q;

	logic [2:0]  cnt;
	logic [31:0] mask;
	logic [63:0] combined;
	logic [2:0]  total;
	logic        accept;
	logic        at_len;

	always_comb begin
		cnt = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
		unique case (cnt)
			3'd0:    mask = 32'h0000_0000;
			3'd1:    mask = 32'hff00_0000;
			3'd2:    mask = 32'hffff_0000;
			3'd3:    mask = 32'hffff_ff00;
			default: mask = 32'hffff_ffff;
		endcase
		combined = {acc_q, 32'h0} | ({msg.data_word & mask, 32'h0} >> {nbytes_q, 3'b000});
		total = {1'b0, nbytes_q} + cnt;
	end

	assign msg.ready = (state_q == S_RUN) && !queue_full;
	assign accept = msg.valid && msg.ready;
	assign at_len = (windex_q + 4'd1) == 4'(LEN_HI_INDEX);

	always_comb begin
		push = 1'b0;
		push_word = '{word: 32'h0, final_blk: 1'b0};
		unique case (state_q)
			S_RUN: begin
				push = accept && (total >= 3'd4);
				push_word.word = combined[63:32];
			end
			S_MARK: begin
				push = !queue_full;
				push_word.word = acc_q | (PAD_MARK >> {nbytes_q, 3'b000});
			end
			S_ZERO: begin
				push = !queue_full;
			end
			S_LENHI: begin
				push = !queue_full;
				push_word.word = bitlen_q[63:32];
			end
			S_LENLO: begin
				push = !queue_full;
				push_word.word = bitlen_q[31:0];
				push_word.final_blk = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			acc_q <= '0;
			nbytes_q <= '0;
			windex_q <= '0;
			bitlen_q <= '0;
		end else begin
			if (push) begin
				windex_q <= windex_q + 4'd1;
			end
			unique case (state_q)
				S_RUN: begin
					if (accept) begin
						if (total >= 3'd4) begin
							acc_q <= combined[31:0];
							nbytes_q <= 2'(total - 3'd4);
						end else begin
							acc_q <= combined[63:32];
							nbytes_q <= total[1:0];
						end
						bitlen_q <= bitlen_q + {58'h0, cnt, 3'b000};
						if (msg.end_of_message) begin
							state_q <= S_MARK;
						end
					end
				end
				S_MARK: begin
					if (push) begin
						acc_q <= '0;
						nbytes_q <= '0;
						state_q <= at_len ? S_LENHI : S_ZERO;
					end
				end
				S_ZERO: begin
					if (push && at_len) begin
						state_q <= S_LENHI;
					end
				end
				S_LENHI: begin
					if (push) begin
						state_q <= S_LENLO;
					end
				end
				S_LENLO: begin
					if (push) begin
						bitlen_q <= '0;
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

endmodule

// File: sv/sha_fifo.sv
// ----------------------------------------------------------------------------
// sha_fifo
// short word queue between the packer and the compression core
// ----------------------------------------------------------------------------
module sha_fifo
	import sha_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qword_t wdata,
	output logic   full,
	input  logic   pop,
	output qword_t rdata,
	output logic   empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	qword_t        mem [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   count_q;

	assign full = count_q == (AW+1)'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// message schedule, 64-round compression and digest output
// ----------------------------------------------------------------------------
module sha_core
	import sha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  qword_t   pop_word,
	input  logic     queue_empty,
	output logic     pop,
	sha_dig_if.source digest
);

	typedef enum logic [1:0] {C_LOAD, C_ROUND, C_ADD, C_OUT} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic        final_q;
	word_t       chain_q [8];
	word_t       w_q [16];
	word_t       v_q [8];
	logic        out_valid_q;
	word_t       out_word_q;
	logic [2:0]  out_index_q;
	logic        out_last_q;

	word_t t1;
	word_t t2;
	word_t w_new;

	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	assign pop = (state_q == C_LOAD) && !queue_empty;

	always_comb begin
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[cnt_q] + w_q[0];
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	end

	assign digest.valid = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index = out_index_q;
	assign digest.last_word = out_last_q;

	// schedule window and working variables
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= pop_word.word;
			if (cnt_q[3:0] == 4'd15) begin
				v_q <= chain_q;
			end
		end else if (state_q == C_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_LOAD;
			cnt_q <= '0;
			final_q <= 1'b0;
			chain_q <= INIT_HASH;
			out_valid_q <= 1'b0;
			out_word_q <= '0;
			out_index_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				C_LOAD: begin
					if (pop) begin
						if (cnt_q[3:0] == 4'd15) begin
							cnt_q <= '0;
							final_q <= pop_word.final_blk;
							state_q <= C_ROUND;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				C_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					if (final_q) begin
						out_valid_q <= 1'b1;
						out_word_q <= chain_q[0] + v_q[0];
						out_index_q <= '0;
						out_last_q <= 1'b0;
						state_q <= C_OUT;
					end else begin
						state_q <= C_LOAD;
					end
				end
				C_OUT: begin
					if (digest.ready) begin
						if (out_last_q) begin
							out_valid_q <= 1'b0;
							out_last_q <= 1'b0;
							chain_q <= INIT_HASH;
							state_q <= C_LOAD;
						end else begin
							out_index_q <= out_index_q + 3'd1;
							out_word_q <= chain_q[out_index_q + 3'd1];
							out_last_q <= (out_index_q + 3'd1) == 3'd7;
						end
					end
				end
				default: state_q <= C_LOAD;
			endcase
		end
	end

endmodule
